// ----- hw/rtl/grmc_pkg.sv -----
// ----------------------------------------------------------------------------
// grmc_pkg: shared definitions for the ground robot mode controller
// Mode codes, configuration register indexes, field widths and types.
// ----------------------------------------------------------------------------
package grmc_pkg;

  // timestamp width, differences wrap modulo 2^TIME_W
  localparam int TIME_W = 32;

  localparam int SPEED_W = 10;
  localparam int BASE_W  = 9;
  localparam int LEN_W   = 16;
  localparam int DRAW_W  = 7;
  localparam int MODE_W  = 4;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic [TIME_W-1:0]         stamp_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [CFG_AW-1:0]         cfg_idx_t;

  // mode codes
  localparam mode_t M_START = 4'd0;
  localparam mode_t M_OWAIT = 4'd1;
  localparam mode_t M_ORUN  = 4'd2;
  localparam mode_t M_OCOLL = 4'd3;
  localparam mode_t M_TWAIT = 4'd4;
  localparam mode_t M_TRUN  = 4'd5;
  localparam mode_t M_NOISE = 4'd6;
  localparam mode_t M_REV   = 4'd7;
  localparam mode_t M_TCOLL = 4'd8;
  localparam mode_t M_TOUCH = 4'd9;

  // configuration register indexes
  localparam cfg_idx_t CFG_BASE_SPEED   = 3'd0;
  localparam cfg_idx_t CFG_NOISE_INTVL  = 3'd1;
  localparam cfg_idx_t CFG_REV_INTVL    = 3'd2;
  localparam cfg_idx_t CFG_NOISE_LEN    = 3'd3;
  localparam cfg_idx_t CFG_REV_LEN      = 3'd4;
  localparam cfg_idx_t CFG_TOUCH_LEN    = 3'd5;

  // configuration reset values
  localparam logic [BASE_W-1:0] BASE_SPEED_RST = 9'd330;
  localparam len_t NOISE_INTVL_RST = 16'd5000;
  localparam len_t REV_INTVL_RST   = 16'd20000;
  localparam len_t NOISE_LEN_RST   = 16'd850;
  localparam len_t REV_LEN_RST     = 16'd2456;
  localparam len_t TOUCH_LEN_RST   = 16'd614;

  // wheel trim in obstacle run and noise draw center, mm/s
  localparam int OBST_TRIM   = 9;
  localparam int NOISE_CTR   = 32;

endpackage

// ----- hw/rtl/ground_robot_mode_controller.sv -----
// ----------------------------------------------------------------------------
// ground_robot_mode_controller: ten-mode wheeled robot controller
// One event beat in, one result beat out: wheel speeds, leds, pulses, mode.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : event beats (valid/ready). Each beat carries the time in ms, the
//           run/wait/top-touch/bumper flags, the target pin and a noise draw.
//   out_* : one result beat per event (valid/ready), in event order, with
//           the held rim speeds, leds, bump/touch pulses and the new mode.
//   cfg_* : write-only register port, one write per cycle when cfg_we is
//           high; write only while no event is in flight.
// Flow
//   An accepted event is held in the input register; the mode logic then
//   updates state and loads the result register once that register is free
//   or draining. One event per cycle sustained while out_ready stays high;
//   the input register refills in the same cycle it hands its beat on.
// Reset
//   rst_n (synchronous, low) empties both registers, returns to start mode,
//   zeroes held speeds and leds and reloads the register defaults. The five
//   timestamps are loaded from the first event after reset.
// Stall
//   With out_ready low the result holds, the input register keeps one more
//   event, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module ground_robot_mode_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  grmc_pkg::cfg_idx_t           cfg_addr,
  input  logic [grmc_pkg::CFG_DW-1:0]  cfg_wdata,
  // event channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [grmc_pkg::TIME_W-1:0]  in_elapsed_ms,
  input  logic                         in_run_cmd,
  input  logic                         in_wait_cmd,
  input  logic                         in_top_touch,
  input  logic                         in_bumper,
  input  logic                         in_target_pin,
  input  logic [grmc_pkg::DRAW_W-1:0]  in_noise_draw,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output grmc_pkg::speed_t             out_left_speed,
  output grmc_pkg::speed_t             out_right_speed,
  output logic                         out_red_led,
  output logic                         out_grn_led,
  output logic                         out_bumped_pulse,
  output logic                         out_top_touched_pulse,
  output grmc_pkg::mode_t              out_mode
);
  import grmc_pkg::*;

  // wide enough for base + 95 and base - 95 without wrap
  localparam int CALC_W = SPEED_W + 2;
  typedef logic signed [CALC_W-1:0] calc_t;

  function automatic speed_t sat10(input calc_t v);
    calc_t hi, lo;
    hi = calc_t'((1 <<< (SPEED_W-1)) - 1);
    lo = -calc_t'(1 <<< (SPEED_W-1));
    if (v > hi)      sat10 = speed_t'(hi);
    else if (v < lo) sat10 = speed_t'(lo);
    else             sat10 = v[SPEED_W-1:0];
  endfunction

  // timer has run out when the wrapped difference exceeds the limit
  function automatic logic expired(input stamp_t now, input stamp_t stamp, input len_t lim);
    stamp_t diff;
    diff = now - stamp;
    expired = diff > stamp_t'(lim);
  endfunction

  // configuration registers
  logic [BASE_W-1:0] base_speed_r;
  len_t noise_intvl_r, rev_intvl_r, noise_len_r, rev_len_r, touch_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r  <= BASE_SPEED_RST;
      noise_intvl_r <= NOISE_INTVL_RST;
      rev_intvl_r   <= REV_INTVL_RST;
      noise_len_r   <= NOISE_LEN_RST;
      rev_len_r     <= REV_LEN_RST;
      touch_len_r   <= TOUCH_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BASE_SPEED:  base_speed_r  <= cfg_wdata[BASE_W-1:0];
        CFG_NOISE_INTVL: noise_intvl_r <= cfg_wdata;
        CFG_REV_INTVL:   rev_intvl_r   <= cfg_wdata;
        CFG_NOISE_LEN:   noise_len_r   <= cfg_wdata;
        CFG_REV_LEN:     rev_len_r     <= cfg_wdata;
        CFG_TOUCH_LEN:   touch_len_r   <= cfg_wdata;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // input register
  logic                in_v_r;
  stamp_t              now_r;
  logic                run_r, wait_r, touch_r, bump_r, pin_r;
  logic [DRAW_W-1:0]   draw_r;

  // result register
  logic                out_v_r;

  // a held event is processed when the result register is free or draining
  logic proc;
  assign proc     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r   <= in_elapsed_ms;
      run_r   <= in_run_cmd;
      wait_r  <= in_wait_cmd;
      touch_r <= in_top_touch;
      bump_r  <= in_bumper;
      pin_r   <= in_target_pin;
      draw_r  <= in_noise_draw;
    end
  end

  // controller state
  mode_t  mode_r, mode_nxt;
  logic   started_r;
  speed_t left_r, left_nxt, right_r, right_nxt;
  logic   red_r, red_nxt, green_r, green_nxt;
  stamp_t noise_begin_r, rev_begin_r, touch_begin_r, noise_last_r, rev_last_r;

  // stamps as seen by this event: the first event after reset sees its own time
  stamp_t noise_begin, rev_begin, touch_begin, noise_last, rev_last;
  assign noise_begin = started_r ? noise_begin_r : now_r;
  assign rev_begin   = started_r ? rev_begin_r   : now_r;
  assign touch_begin = started_r ? touch_begin_r : now_r;
  assign noise_last  = started_r ? noise_last_r  : now_r;
  assign rev_last    = started_r ? rev_last_r    : now_r;

  // stamp update strobes
  logic set_noise_begin, set_rev_begin, set_touch_begin, set_noise_last, set_rev_last;
  logic bumped, touched;

  // wheel set-points for each kind of mode entry
  calc_t  base_c, off_c, half_c;
  speed_t orun_l, orun_r, trun_s, spin_l, spin_r, noise_l, noise_r;

  always_comb begin
    base_c  = calc_t'(base_speed_r);
    off_c   = calc_t'(draw_r) - calc_t'(NOISE_CTR);
    half_c  = calc_t'(base_speed_r >> 1);
    orun_l  = sat10(base_c - calc_t'(OBST_TRIM));
    orun_r  = sat10(base_c + calc_t'(OBST_TRIM));
    trun_s  = sat10(base_c);
    spin_l  = sat10(half_c);
    spin_r  = sat10(-half_c);
    noise_l = sat10(base_c - off_c);
    noise_r = sat10(base_c + off_c);
  end

  always_comb begin
    mode_nxt        = mode_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    set_noise_begin = 1'b0;
    set_rev_begin   = 1'b0;
    set_touch_begin = 1'b0;
    set_noise_last  = 1'b0;
    set_rev_last    = 1'b0;
    bumped          = 1'b0;
    touched         = 1'b0;

    unique case (mode_r)
      M_START: begin
        if (pin_r) begin
          green_nxt = 1'b1;
          mode_nxt  = M_TWAIT;
        end else begin
          red_nxt  = 1'b1;
          mode_nxt = M_OWAIT;
        end
      end
      M_OWAIT: begin
        if (run_r) begin
          red_nxt   = 1'b1;
          green_nxt = 1'b0;
          left_nxt  = orun_l;
          right_nxt = orun_r;
          mode_nxt  = M_ORUN;
        end
      end
      M_ORUN: begin
        if (wait_r) begin
          left_nxt  = '0;
          right_nxt = '0;
          red_nxt   = 1'b1;
          mode_nxt  = M_OWAIT;
        end else if (bump_r) begin
          left_nxt  = '0;
          right_nxt = '0;
          red_nxt   = 1'b1;
          green_nxt = 1'b1;
          mode_nxt  = M_OCOLL;
        end
      end
      M_OCOLL: begin
        if (wait_r) begin
          red_nxt  = 1'b1;
          mode_nxt = M_OWAIT;
        end else if (!bump_r) begin
          red_nxt   = 1'b1;
          green_nxt = 1'b0;
          left_nxt  = orun_l;
          right_nxt = orun_r;
          mode_nxt  = M_ORUN;
        end
      end
      M_TWAIT: begin
        if (run_r) begin
          set_noise_last = 1'b1;
          set_rev_last   = 1'b1;
          left_nxt       = trun_s;
          right_nxt      = trun_s;
          green_nxt      = 1'b1;
          red_nxt        = 1'b0;
          mode_nxt       = M_TRUN;
        end
      end
      M_TRUN: begin
        if (wait_r) begin
          green_nxt = 1'b1;
          mode_nxt  = M_TWAIT;
        end else if (touch_r) begin
          left_nxt        = spin_l;
          right_nxt       = spin_r;
          red_nxt         = 1'b1;
          set_touch_begin = 1'b1;
          mode_nxt        = M_TOUCH;
        end else if (expired(now_r, rev_last, rev_intvl_r)) begin
          set_rev_last  = 1'b1;
          left_nxt      = spin_l;
          right_nxt     = spin_r;
          red_nxt       = 1'b1;
          set_rev_begin = 1'b1;
          mode_nxt      = M_REV;
        end else if (expired(now_r, noise_last, noise_intvl_r)) begin
          left_nxt        = noise_l;
          right_nxt       = noise_r;
          red_nxt         = 1'b1;
          set_noise_begin = 1'b1;
          mode_nxt        = M_NOISE;
        end else if (bump_r) begin
          left_nxt  = '0;
          right_nxt = '0;
          mode_nxt  = M_TCOLL;
        end
      end
      M_NOISE: begin
        if (wait_r) begin
          green_nxt = 1'b1;
          mode_nxt  = M_TWAIT;
        end else if (touch_r) begin
          left_nxt        = spin_l;
          right_nxt       = spin_r;
          red_nxt         = 1'b1;
          set_touch_begin = 1'b1;
          mode_nxt        = M_TOUCH;
        end else if (expired(now_r, noise_begin, noise_len_r)) begin
          set_noise_last = 1'b1;
          left_nxt       = trun_s;
          right_nxt      = trun_s;
          green_nxt      = 1'b1;
          red_nxt        = 1'b0;
          mode_nxt       = M_TRUN;
        end else if (bump_r) begin
          left_nxt  = '0;
          right_nxt = '0;
          mode_nxt  = M_TCOLL;
        end
      end
      M_REV: begin
        if (wait_r) begin
          green_nxt = 1'b1;
          mode_nxt  = M_TWAIT;
        end else if (touch_r) begin
          left_nxt        = spin_l;
          right_nxt       = spin_r;
          red_nxt         = 1'b1;
          set_touch_begin = 1'b1;
          mode_nxt        = M_TOUCH;
        end else if (expired(now_r, rev_begin, rev_len_r)) begin
          left_nxt  = trun_s;
          right_nxt = trun_s;
          green_nxt = 1'b1;
          red_nxt   = 1'b0;
          mode_nxt  = M_TRUN;
        end
      end
      M_TCOLL: begin
        // collision always backs off into a reversal spin
        bumped        = 1'b1;
        left_nxt      = spin_l;
        right_nxt     = spin_r;
        red_nxt       = 1'b1;
        set_rev_begin = 1'b1;
        mode_nxt      = M_REV;
      end
      M_TOUCH: begin
        touched = 1'b1;
        if (wait_r) begin
          green_nxt = 1'b1;
          mode_nxt  = M_TWAIT;
        end else if (expired(now_r, touch_begin, touch_len_r)) begin
          left_nxt  = trun_s;
          right_nxt = trun_s;
          green_nxt = 1'b1;
          red_nxt   = 1'b0;
          mode_nxt  = M_TRUN;
        end else if (bump_r) begin
          left_nxt  = '0;
          right_nxt = '0;
          mode_nxt  = M_TCOLL;
        end
      end
      default: ;  // unused codes hold everything
    endcase
  end

  // state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_START;
      started_r <= 1'b0;
      left_r    <= '0;
      right_r   <= '0;
      red_r     <= 1'b0;
      green_r   <= 1'b0;
    end else if (proc) begin
      mode_r    <= mode_nxt;
      started_r <= 1'b1;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
    end
  end

  // timestamps, all loaded by the first event after reset
  always_ff @(posedge clk) begin
    if (proc) begin
      if (!started_r || set_noise_begin) noise_begin_r <= now_r;
      if (!started_r || set_rev_begin)   rev_begin_r   <= now_r;
      if (!started_r || set_touch_begin) touch_begin_r <= now_r;
      if (!started_r || set_noise_last)  noise_last_r  <= now_r;
      if (!started_r || set_rev_last)    rev_last_r    <= now_r;
    end
  end

  // result register
  speed_t out_left_r, out_right_r;
  logic   out_red_r, out_green_r, out_bumped_r, out_touched_r;
  mode_t  out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_left_r    <= left_nxt;
      out_right_r   <= right_nxt;
      out_red_r     <= red_nxt;
      out_green_r   <= green_nxt;
      out_bumped_r  <= bumped;
      out_touched_r <= touched;
      out_mode_r    <= mode_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_left_speed        = out_left_r;
  assign out_right_speed       = out_right_r;
  assign out_red_led           = out_red_r;
  assign out_grn_led           = out_green_r;
  assign out_bumped_pulse      = out_bumped_r;
  assign out_top_touched_pulse = out_touched_r;
  assign out_mode              = out_mode_r;

endmodule

// ----- hw/rtl/grmc_checker.sv -----
// ----------------------------------------------------------------------------
// grmc_checker: port-level checks for the mode controller
// Watches the result channel and the mode/led relations it must show.
// ----------------------------------------------------------------------------
module grmc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input grmc_pkg::speed_t             out_left_speed,
  input grmc_pkg::speed_t             out_right_speed,
  input logic                         out_red_led,
  input logic                         out_grn_led,
  input logic                         out_bumped_pulse,
  input logic                         out_top_touched_pulse,
  input grmc_pkg::mode_t              out_mode
);
  import grmc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode)
      && $stable(out_left_speed) && $stable(out_right_speed))
    else $error("result beat changed while stalled");

  // nothing is in flight right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a handled collision always leaves for the reversal spin with red lit
  a_bump_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bumped_pulse |-> out_mode == M_REV && out_red_led
      && !out_top_touched_pulse)
    else $error("bump pulse without reversal");

  // top-touch steps end in wait, run, collision or touch
  a_touch_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_top_touched_pulse |-> out_mode == M_TWAIT
      || out_mode == M_TRUN || out_mode == M_TCOLL || out_mode == M_TOUCH)
    else $error("top-touch pulse with bad mode");

  // obstacle collision stops the wheels with both leds lit
  a_ocoll_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == M_OCOLL |-> out_left_speed == '0
      && out_right_speed == '0 && out_red_led && out_grn_led)
    else $error("obstacle collision without stop");

endmodule

bind ground_robot_mode_controller grmc_checker u_grmc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_left_speed        (out_left_speed),
  .out_right_speed       (out_right_speed),
  .out_red_led           (out_red_led),
  .out_grn_led           (out_grn_led),
  .out_bumped_pulse      (out_bumped_pulse),
  .out_top_touched_pulse (out_top_touched_pulse),
  .out_mode              (out_mode)
);

// ----- tb/grmc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// grmc_tb_pkg: beat types and drive scoreboard for the mode controller bench
// Holds a cycle-free copy of the controller's modes, timers and held outputs,
// predicts one drive beat per event and compares it with the block's beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package grmc_tb_pkg;

  import grmc_pkg::*;

  localparam int SPEED_MAX   = 2 ** (SPEED_W - 1) - 1;
  localparam int SPEED_MIN   = -(2 ** (SPEED_W - 1));
  localparam int MAX_REPORTS = 10;

  typedef logic [DRAW_W-1:0] draw_t;

  typedef struct packed {
    stamp_t elapsed;
    logic   run_cmd;
    logic   wait_cmd;
    logic   top_touch;
    logic   bumper;
    logic   target_pin;
    draw_t  draw;
  } event_t;

  typedef struct packed {
    speed_t left_speed;
    speed_t right_speed;
    logic   red_led;
    logic   grn_led;
    logic   bumped;
    logic   touched;
    mode_t  mode;
  } drive_t;

  class drive_scoreboard;

    // register copy
    logic [BASE_W-1:0] base_speed;
    len_t              noise_intvl, rev_intvl, noise_len, rev_len, touch_len;

    // controller state copy
    mode_t  cur_mode;
    stamp_t noise_begin, rev_begin, touch_begin, noise_last, rev_last;
    bit     started;
    speed_t left_hold, right_hold;
    bit     red_hold, green_hold;

    drive_t    expected_drive[$];
    int        events_noted, beats_checked, error_count;
    int        sat_count, bump_count, touch_count;
    bit [15:0] modes_seen;

    function new();
      base_speed  = BASE_SPEED_RST;
      noise_intvl = NOISE_INTVL_RST;
      rev_intvl   = REV_INTVL_RST;
      noise_len   = NOISE_LEN_RST;
      rev_len     = REV_LEN_RST;
      touch_len   = TOUCH_LEN_RST;
      cur_mode    = M_START;
      started     = 1'b0;
      left_hold   = '0;
      right_hold  = '0;
      red_hold    = 1'b0;
      green_hold  = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_BASE_SPEED:  base_speed  = value[BASE_W-1:0];
        CFG_NOISE_INTVL: noise_intvl = value;
        CFG_REV_INTVL:   rev_intvl   = value;
        CFG_NOISE_LEN:   noise_len   = value;
        CFG_REV_LEN:     rev_len     = value;
        CFG_TOUCH_LEN:   touch_len   = value;
        default: ;
      endcase
    endfunction

    function speed_t clamp(int v);
      if (v > SPEED_MAX) begin
        sat_count++;
        return speed_t'(SPEED_MAX);
      end
      if (v < SPEED_MIN) begin
        sat_count++;
        return speed_t'(SPEED_MIN);
      end
      return speed_t'(v);
    endfunction

    function void set_wheels(int l, int r);
      left_hold  = clamp(l);
      right_hold = clamp(r);
    endfunction

    // elapsed time wraps, strictly greater means expired
    function bit timer_done(stamp_t now, stamp_t stamp, len_t lim);
      stamp_t diff;
      diff = now - stamp;
      return diff > stamp_t'(lim);
    endfunction

    function void go_obstacle_run();
      red_hold   = 1'b1;
      green_hold = 1'b0;
      set_wheels(int'(base_speed) - OBST_TRIM, int'(base_speed) + OBST_TRIM);
    endfunction

    function void go_target_run();
      set_wheels(int'(base_speed), int'(base_speed));
      green_hold = 1'b1;
      red_hold   = 1'b0;
    endfunction

    function void go_spin();
      int h;
      h = int'(base_speed) / 2;
      set_wheels(h, -h);
      red_hold = 1'b1;
    endfunction

    function void note_event(event_t ev);
      mode_t  m;
      stamp_t t;
      bit     bumped, touched;
      int     off;
      drive_t want;
      m       = cur_mode;
      t       = ev.elapsed;
      bumped  = 1'b0;
      touched = 1'b0;
      if (!started) begin
        noise_begin = t;
        rev_begin   = t;
        touch_begin = t;
        noise_last  = t;
        rev_last    = t;
        started     = 1'b1;
      end
      case (m)
        M_START: begin
          if (ev.target_pin) begin
            green_hold = 1'b1;
            m = M_TWAIT;
          end else begin
            red_hold = 1'b1;
            m = M_OWAIT;
          end
        end
        M_OWAIT: begin
          if (ev.run_cmd) begin
            go_obstacle_run();
            m = M_ORUN;
          end
        end
        M_ORUN: begin
          if (ev.wait_cmd) begin
            set_wheels(0, 0);
            red_hold = 1'b1;
            m = M_OWAIT;
          end else if (ev.bumper) begin
            set_wheels(0, 0);
            red_hold   = 1'b1;
            green_hold = 1'b1;
            m = M_OCOLL;
          end
        end
        M_OCOLL: begin
          if (ev.wait_cmd) begin
            red_hold = 1'b1;
            m = M_OWAIT;
          end else if (!ev.bumper) begin
            go_obstacle_run();
            m = M_ORUN;
          end
        end
        M_TWAIT: begin
          if (ev.run_cmd) begin
            noise_last = t;
            rev_last   = t;
            go_target_run();
            m = M_TRUN;
          end
        end
        M_TRUN: begin
          if (ev.wait_cmd) begin
            green_hold = 1'b1;
            m = M_TWAIT;
          end else if (ev.top_touch) begin
            go_spin();
            touch_begin = t;
            m = M_TOUCH;
          end else if (timer_done(t, rev_last, rev_intvl)) begin
            rev_last = t;
            go_spin();
            rev_begin = t;
            m = M_REV;
          end else if (timer_done(t, noise_last, noise_intvl)) begin
            off = int'(ev.draw) - NOISE_CTR;
            set_wheels(int'(base_speed) - off, int'(base_speed) + off);
            red_hold    = 1'b1;
            noise_begin = t;
            m = M_NOISE;
          end else if (ev.bumper) begin
            set_wheels(0, 0);
            m = M_TCOLL;
          end
        end
        M_NOISE: begin
          if (ev.wait_cmd) begin
            green_hold = 1'b1;
            m = M_TWAIT;
          end else if (ev.top_touch) begin
            go_spin();
            touch_begin = t;
            m = M_TOUCH;
          end else if (timer_done(t, noise_begin, noise_len)) begin
            noise_last = t;
            go_target_run();
            m = M_TRUN;
          end else if (ev.bumper) begin
            set_wheels(0, 0);
            m = M_TCOLL;
          end
        end
        M_REV: begin
          if (ev.wait_cmd) begin
            green_hold = 1'b1;
            m = M_TWAIT;
          end else if (ev.top_touch) begin
            go_spin();
            touch_begin = t;
            m = M_TOUCH;
          end else if (timer_done(t, rev_begin, rev_len)) begin
            go_target_run();
            m = M_TRUN;
          end
        end
        M_TCOLL: begin
          bumped = 1'b1;
          go_spin();
          rev_begin = t;
          m = M_REV;
        end
        M_TOUCH: begin
          touched = 1'b1;
          if (ev.wait_cmd) begin
            green_hold = 1'b1;
            m = M_TWAIT;
          end else if (timer_done(t, touch_begin, touch_len)) begin
            go_target_run();
            m = M_TRUN;
          end else if (ev.bumper) begin
            set_wheels(0, 0);
            m = M_TCOLL;
          end
        end
        default: ;
      endcase
      cur_mode = m;
      events_noted++;
      bump_count  += bumped;
      touch_count += touched;
      want.left_speed  = left_hold;
      want.right_speed = right_hold;
      want.red_led     = red_hold;
      want.grn_led     = green_hold;
      want.bumped      = bumped;
      want.touched     = touched;
      want.mode        = cur_mode;
      expected_drive.push_back(want);
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      beats_checked++;
      modes_seen[got.mode] = 1'b1;
      if (expected_drive.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("drive beat %0d arrived with no event pending", beats_checked);
        return;
      end
      want = expected_drive.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("drive beat %0d mismatch at %0t", beats_checked, $time);
          $display("  exp L=%0d R=%0d red=%b grn=%b bump=%b touch=%b mode=%0d",
                   want.left_speed, want.right_speed, want.red_led, want.grn_led,
                   want.bumped, want.touched, want.mode);
          $display("  got L=%0d R=%0d red=%b grn=%b bump=%b touch=%b mode=%0d",
                   got.left_speed, got.right_speed, got.red_led, got.grn_led,
                   got.bumped, got.touched, got.mode);
        end
      end
    endfunction

  endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ground robot mode controller
// Drives event beats with random gaps, stalls the drive channel at random,
// predicts every drive beat in a scoreboard and compares field by field.
// Runs a directed walk through the timers first, then six register settings
// with random events, including zero and maximum timer lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  import grmc_pkg::*;
  import grmc_tb_pkg::*;

  localparam int       ITEMS_PER_PHASE = 190;
  localparam int       CYCLE_LIMIT     = 300000;
  localparam int       TAIL_CYCLES     = 4;
  // index that no register decodes, writes there must change nothing
  localparam cfg_idx_t CFG_SPARE       = 3'd7;
  // start of the directed walk, close to the wrap of the ms counter
  localparam stamp_t   WALK_T0         = 32'hFFFF_FFC0;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_addr;
  logic [CFG_DW-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_elapsed_ms;
  logic                 in_run_cmd;
  logic                 in_wait_cmd;
  logic                 in_top_touch;
  logic                 in_bumper;
  logic                 in_target_pin;
  logic [DRAW_W-1:0]    in_noise_draw;
  logic                 out_valid;
  logic                 out_ready;
  speed_t               out_left_speed;
  speed_t               out_right_speed;
  logic                 out_red_led;
  logic                 out_grn_led;
  logic                 out_bumped_pulse;
  logic                 out_top_touched_pulse;
  mode_t                out_mode;

  drive_scoreboard sb = new();

  drive_t seen_drive;
  int     cycle_count = 0;
  int     stall_left  = 0;
  bit     bursting    = 1'b0;   // no gaps on either side while set
  bit     target_path;          // family chosen by the first event
  stamp_t now_ms;

  ground_robot_mode_controller dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_elapsed_ms         (in_elapsed_ms),
    .in_run_cmd            (in_run_cmd),
    .in_wait_cmd           (in_wait_cmd),
    .in_top_touch          (in_top_touch),
    .in_bumper             (in_bumper),
    .in_target_pin         (in_target_pin),
    .in_noise_draw         (in_noise_draw),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_speed        (out_left_speed),
    .out_right_speed       (out_right_speed),
    .out_red_led           (out_red_led),
    .out_grn_led           (out_grn_led),
    .out_bumped_pulse      (out_bumped_pulse),
    .out_top_touched_pulse (out_top_touched_pulse),
    .out_mode              (out_mode)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit, reckoned far above the slowest clean run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d drive beats still pending",
             cycle_count, sb.expected_drive.size());
    $display("tb_top: errors");
    $finish;
  end

  // drive side ready: low while a drawn stall is still counting down
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (stall_left == 0);
    end
  end

  // sample drive beats at the rising edge, draw the stall after each beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_drive.left_speed  = out_left_speed;
      seen_drive.right_speed = out_right_speed;
      seen_drive.red_led     = out_red_led;
      seen_drive.grn_led     = out_grn_led;
      seen_drive.bumped      = out_bumped_pulse;
      seen_drive.touched     = out_top_touched_pulse;
      seen_drive.mode        = out_mode;
      sb.check_result(seen_drive);
      stall_left = bursting ? 0 : $urandom_range(0, 8);
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  // one register write, only ever issued with nothing in flight
  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CFG_DW-1:0] base, input len_t n_int,
                                input len_t r_int, input len_t n_len,
                                input len_t r_len, input len_t t_len);
    write_cfg(CFG_BASE_SPEED,  base);
    write_cfg(CFG_NOISE_INTVL, n_int);
    write_cfg(CFG_REV_INTVL,   r_int);
    write_cfg(CFG_NOISE_LEN,   n_len);
    write_cfg(CFG_REV_LEN,     r_len);
    write_cfg(CFG_TOUCH_LEN,   t_len);
  endtask

  // one event beat: optional gap with valid low, then hold valid until accepted
  task automatic send_event(input event_t ev);
    int gap;
    gap = bursting ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_elapsed_ms <= ev.elapsed;
    in_run_cmd    <= ev.run_cmd;
    in_wait_cmd   <= ev.wait_cmd;
    in_top_touch  <= ev.top_touch;
    in_bumper     <= ev.bumper;
    in_target_pin <= ev.target_pin;
    in_noise_draw <= ev.draw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(ev);
  endtask

  // stop sending and wait until every predicted drive beat has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic event_t make_event(input stamp_t t, input bit run, input bit wt,
                                        input bit touch, input bit bump, input bit pin,
                                        input draw_t draw);
    event_t ev;
    ev.elapsed    = t;
    ev.run_cmd    = run;
    ev.wait_cmd   = wt;
    ev.top_touch  = touch;
    ev.bumper     = bump;
    ev.target_pin = pin;
    ev.draw       = draw;
    return ev;
  endfunction

  // directed walk: written for the target path with short timers, the
  // obstacle path still sees run, wait and bumper in every combination
  task automatic run_directed();
    bursting = 1'b0;
    apply_settings(16'd511, 16'd100, 16'd1000, 16'd50, 16'd80, 16'd30);
    write_cfg(CFG_SPARE, 16'hFFFF);
    //                    time              run  wait tch  bmp  pin          draw
    send_event(make_event(WALK_T0,          0,   0,   0,   0,   target_path, 7'd0));
    send_event(make_event(WALK_T0 + 5,      1,   0,   0,   0,   0,           7'd0));
    // noise gap equal to the interval: not yet expired
    send_event(make_event(WALK_T0 + 105,    0,   0,   0,   0,   1,           7'd32));
    // one past, noise turn with top draw: right wheel saturates
    send_event(make_event(WALK_T0 + 106,    0,   0,   0,   0,   0,           7'd127));
    send_event(make_event(WALK_T0 + 156,    0,   0,   0,   0,   0,           7'd64));
    // noise turn over beats the bumper
    send_event(make_event(WALK_T0 + 157,    0,   0,   0,   1,   0,           7'd0));
    send_event(make_event(WALK_T0 + 160,    0,   0,   0,   1,   0,           7'd0));
    // collision handled: bump pulse and odd-base spin
    send_event(make_event(WALK_T0 + 161,    0,   0,   0,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 241,    0,   0,   0,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 242,    0,   0,   0,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 243,    0,   0,   1,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 250,    0,   0,   0,   1,   0,           7'd0));
    send_event(make_event(WALK_T0 + 251,    0,   0,   0,   0,   0,           7'd0));
    // top touch wins over bumper in reverse
    send_event(make_event(WALK_T0 + 252,    0,   0,   1,   1,   0,           7'd0));
    send_event(make_event(WALK_T0 + 282,    0,   0,   0,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 283,    0,   0,   0,   0,   0,           7'd0));
    send_event(make_event(WALK_T0 + 284,    0,   1,   1,   1,   0,           7'd0));
    send_event(make_event(WALK_T0 + 290,    1,   1,   0,   0,   0,           7'd0));
    // both timers expired at once, reversal takes priority
    send_event(make_event(WALK_T0 + 1291,   0,   0,   0,   0,   0,           7'd5));
    send_event(make_event(WALK_T0 + 1292,   0,   1,   0,   0,   0,           7'd0));
    send_event(make_event(32'h0000_0000,    1,   0,   0,   0,   0,           7'd0));
    send_event(make_event(32'hFFFF_FFFF,    1,   1,   1,   1,   1,           7'd127));
    send_event(make_event(32'h8000_0000,    1,   0,   0,   1,   0,           7'd96));
    now_ms = 32'h8000_0000;
    drain_results();
  endtask

  // random events with time advancing by up to step_max ms per beat and
  // an occasional jump anywhere on the ms counter
  task automatic run_random_phase(input int count, input int unsigned step_max,
                                  input bit hold_midway);
    event_t ev;
    int     pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) bursting = ($urandom_range(0, 3) == 0);
      // sender holds off until the block has answered everything
      if (hold_midway && i == count / 2) drain_results();
      pick = $urandom_range(0, 63);
      if (pick == 0) now_ms = $urandom();
      else if (pick > 3) now_ms += $urandom_range(0, step_max);
      ev.elapsed    = now_ms;
      ev.run_cmd    = ($urandom_range(0, 2) == 0);
      ev.wait_cmd   = ($urandom_range(0, 9) == 0);
      ev.top_touch  = ($urandom_range(0, 11) == 0);
      ev.bumper     = ($urandom_range(0, 4) == 0);
      ev.target_pin = ($urandom_range(0, 1) == 1);
      ev.draw       = ($urandom_range(0, 7) == 0) ? draw_t'($urandom_range(0, 127))
                                                  : draw_t'($urandom_range(0, 64));
      send_event(ev);
    end
    drain_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_BASE_SPEED;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_elapsed_ms = '0;
    in_run_cmd    = 1'b0;
    in_wait_cmd   = 1'b0;
    in_top_touch  = 1'b0;
    in_bumper     = 1'b0;
    in_target_pin = 1'b0;
    in_noise_draw = '0;
    // the first event fixes obstacle or target behavior for the whole run
    target_path   = ($urandom_range(0, 3) != 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // every timer zero: any nonzero difference expires, base speed zero
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_phase(ITEMS_PER_PHASE, 3, 1'b0);

    // every timer at its largest, long strides
    apply_settings(16'd400, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_phase(ITEMS_PER_PHASE, 25000, 1'b0);

    // fastest wheels with short timers, hits saturation often
    apply_settings(16'd511, 16'd200, 16'd1500, 16'd60, 16'd100, 16'd40);
    run_random_phase(ITEMS_PER_PHASE, 60, 1'b1);

    // power-on values
    apply_settings(16'(BASE_SPEED_RST), NOISE_INTVL_RST, REV_INTVL_RST,
                   NOISE_LEN_RST, REV_LEN_RST, TOUCH_LEN_RST);
    run_random_phase(ITEMS_PER_PHASE, 1500, 1'b0);

    // odd base speed, random timers
    apply_settings(16'(($urandom_range(0, 199) * 2) + 1), len_t'($urandom_range(1, 3000)),
                   len_t'($urandom_range(1, 6000)), len_t'($urandom_range(1, 800)),
                   len_t'($urandom_range(1, 800)), len_t'($urandom_range(1, 800)));
    run_random_phase(ITEMS_PER_PHASE, 800, 1'b0);

    apply_settings(16'($urandom_range(0, 400)), len_t'($urandom_range(1, 1500)),
                   len_t'($urandom_range(1, 4000)), len_t'($urandom_range(1, 400)),
                   len_t'($urandom_range(1, 400)), len_t'($urandom_range(1, 400)));
    run_random_phase(ITEMS_PER_PHASE, 400, 1'b0);

    $display("run covered %0d events on the %s path, drive modes seen %b",
             sb.events_noted, target_path ? "target" : "obstacle", sb.modes_seen);
    $display("saturated speeds %0d, bump pulses %0d, top-touch pulses %0d, failures %0d",
             sb.sat_count, sb.bump_count, sb.touch_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/grmc_pkg.sv
hw/rtl/ground_robot_mode_controller.sv
hw/rtl/grmc_checker.sv
tb/grmc_tb_pkg.sv
tb/tb_top.sv
